### design/pixel_to_view_angle_core_assert.svh
// ----------------------------------------------------------------------------
// pixel_to_view_angle_core assertion macros
// clocked checks with reset masking, used by pixel_to_view_angle_core
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_VIEW_ANGLE_CORE_ASSERT_SVH
`define PIXEL_TO_VIEW_ANGLE_CORE_ASSERT_SVH

// plain property, checked on every edge out of reset
`define PVAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication
`define PVAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pvac_pkg.sv
// ----------------------------------------------------------------------------
// pvac_pkg
// types, constants and the angle rounding for the pixel to view angle core
// ----------------------------------------------------------------------------
`default_nettype none

package pvac_pkg;

    typedef struct packed {
        logic [15:0] pixel_u;
        logic [15:0] pixel_v;
    } pvac_in_t;

    typedef struct packed {
        logic signed [15:0] azimuth;
        logic signed [15:0] elevation;
    } pvac_out_t;

    localparam int ZW = 25;
    localparam int W1 = 44;
    localparam int W2 = 62;
    localparam int GUARD_BITS = 24;
    localparam int TABLE_LEN = 32;

    localparam logic signed [25:0] GAIN_Q24 = 26'sd27628053;
    localparam logic signed [17:0] ANGLE_LIMIT = 18'sd23040;

    localparam logic [1:0] REG_FOCAL_X  = 2'd0;
    localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
    localparam logic [1:0] REG_CENTER_X = 2'd2;
    localparam logic [1:0] REG_CENTER_Y = 2'd3;

    // atan(2^-i) in 1/65536 degree
    localparam logic signed [23:0] ATAN_TABLE [TABLE_LEN] = '{
        24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945,
        24'sd234379,  24'sd117304,  24'sd58666,  24'sd29335,
        24'sd14668,   24'sd7334,    24'sd3667,   24'sd1833,
        24'sd917,     24'sd458,     24'sd229,    24'sd115,
        24'sd57,      24'sd29,      24'sd14,     24'sd7,
        24'sd4,       24'sd2,       24'sd1,      24'sd0,
        24'sd0,       24'sd0,       24'sd0,      24'sd0,
        24'sd0,       24'sd0,       24'sd0,      24'sd0
    };

    // negate, round half up to 1/256 degree, clamp to +/-90 degrees
    function automatic logic signed [15:0] pvac_to_angle(input logic signed [ZW-1:0] z);
        logic signed [ZW:0] d;
        logic signed [17:0] r;
        begin
            d = 26'sd128 - ZW'(z);
            r = 18'(d >>> 8);
            if (r > ANGLE_LIMIT)
            begin
                r = ANGLE_LIMIT;
            end
            else if (r < -ANGLE_LIMIT)
            begin
                r = -ANGLE_LIMIT;
            end
            return r[15:0];
        end
    endfunction

endpackage

`default_nettype wire

### design/pvac_cell.sv
// ----------------------------------------------------------------------------
// pvac_cell
// one vectoring cordic micro-rotation with a fixed shift, registered
// ----------------------------------------------------------------------------
`default_nettype none

module pvac_cell
    import pvac_pkg::*;
#(
    parameter int W = 44,
    parameter int SIDE_W = 16,
    parameter int STAGE = 0
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                ce,
    input  wire logic                valid_in,
    input  wire logic signed [W-1:0] x_in,
    input  wire logic signed [W-1:0] y_in,
    input  wire logic signed [ZW-1:0] z_in,
    input  wire logic [SIDE_W-1:0]   side_in,
    output logic                     valid_out,
    output logic signed [W-1:0]      x_out,
    output logic signed [W-1:0]      y_out,
    output logic signed [ZW-1:0]     z_out,
    output logic [SIDE_W-1:0]        side_out
);

    logic                valid_reg;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [SIDE_W-1:0]   side_reg;
    logic signed [W-1:0] xs, ys;
    logic signed [ZW-1:0] t;

    always_comb
    begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        t  = ZW'(ATAN_TABLE[STAGE]);
        if (!y_in[W-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + t;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

### design/pvac_pass.sv
// ----------------------------------------------------------------------------
// pvac_pass
// vectoring cordic pass built as a row of micro-rotation cells
// ----------------------------------------------------------------------------
`default_nettype none

module pvac_pass
    import pvac_pkg::*;
#(
    parameter int W = 44,
    parameter int SIDE_W = 16,
    parameter int STAGES = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                ce,
    input  wire logic                valid_in,
    input  wire logic signed [W-1:0] x_in,
    input  wire logic signed [W-1:0] y_in,
    input  wire logic [SIDE_W-1:0]   side_in,
    output logic                     valid_out,
    output logic signed [W-1:0]      x_out,
    output logic signed [ZW-1:0]     z_out,
    output logic [SIDE_W-1:0]        side_out
);

    logic                v_s    [STAGES+1];
    logic signed [W-1:0] x_s    [STAGES+1];
    logic signed [W-1:0] y_s    [STAGES+1];
    logic signed [ZW-1:0] z_s   [STAGES+1];
    logic [SIDE_W-1:0]   side_s [STAGES+1];

    assign v_s[0]    = valid_in;
    assign x_s[0]    = x_in;
    assign y_s[0]    = y_in;
    assign z_s[0]    = '0;
    assign side_s[0] = side_in;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        pvac_cell #(
            .W      (W),
            .SIDE_W (SIDE_W),
            .STAGE  (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .valid_in  (v_s[i]),
            .x_in      (x_s[i]),
            .y_in      (y_s[i]),
            .z_in      (z_s[i]),
            .side_in   (side_s[i]),
            .valid_out (v_s[i+1]),
            .x_out     (x_s[i+1]),
            .y_out     (y_s[i+1]),
            .z_out     (z_s[i+1]),
            .side_out  (side_s[i+1])
        );
    end

    assign valid_out = v_s[STAGES];
    assign x_out     = x_s[STAGES];
    assign z_out     = z_s[STAGES];
    assign side_out  = side_s[STAGES];

endmodule

`default_nettype wire

### design/pixel_to_view_angle_core.sv
// ----------------------------------------------------------------------------
// pixel_to_view_angle_core
// pinhole camera pixel position to viewing azimuth and elevation
// ----------------------------------------------------------------------------
// channel  | direction | handshake             | payload
// pix      | in        | pix_valid / pix_stall | pvac_in_t  (pixel_u, pixel_v)
// ang      | out       | ang_valid / ang_stall | pvac_out_t (azimuth, elevation)
// apb      | in        | psel / penable        | focal_x, focal_y, center_x, center_y
//
// one request per cycle while no result waits under ang_stall; a request passes
// the two cordic cell rows and six setup / product / output registers
// the whole pipe holds while a result waits under ang_stall
// reset clears the valid bits and loads the default camera registers
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_to_view_angle_core
    import pvac_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pix_valid,
    output logic             pix_stall,
    input  wire pvac_in_t    pix,
    output logic             ang_valid,
    input  wire logic        ang_stall,
    output pvac_out_t        ang,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

`include "pixel_to_view_angle_core_assert.svh"

    logic [15:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [15:0] fxe, fye;
    logic        ce;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= 16'd8192;
            focal_y_reg  <= 16'd8192;
            center_x_reg <= 16'd5120;
            center_y_reg <= 16'd3840;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_FOCAL_X:  focal_x_reg  <= pwdata[15:0];
                REG_FOCAL_Y:  focal_y_reg  <= pwdata[15:0];
                REG_CENTER_X: center_x_reg <= pwdata[15:0];
                REG_CENTER_Y: center_y_reg <= pwdata[15:0];
                default:      focal_x_reg  <= focal_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FOCAL_X:  prdata = {16'd0, focal_x_reg};
            REG_FOCAL_Y:  prdata = {16'd0, focal_y_reg};
            REG_CENTER_X: prdata = {16'd0, center_x_reg};
            REG_CENTER_Y: prdata = {16'd0, center_y_reg};
            default:      prdata = '0;
        endcase
    end

    // a zero focal length counts as one
    assign fxe = (focal_x_reg == 16'd0) ? 16'd1 : focal_x_reg;
    assign fye = (focal_y_reg == 16'd0) ? 16'd1 : focal_y_reg;

    assign ce        = !(ang_valid && ang_stall);
    assign pix_stall = !ce;

    // stage 0: offsets from the principal point
    logic               s0_valid_reg;
    logic signed [16:0] du0_reg, dv0_reg;

    // stage 1: dv * fx and pass 1 start vector
    logic               s1_valid_reg;
    logic signed [33:0] dvfx_reg;
    logic signed [W1-1:0] x1i_reg, y1i_reg;

    // stage 2: scale by the cordic gain
    logic               s2_valid_reg;
    logic signed [58:0] y2i_reg;
    logic signed [W1-1:0] x1s_reg, y1s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            s0_valid_reg <= pix_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            du0_reg  <= $signed({1'b0, pix.pixel_u}) - $signed({1'b0, center_x_reg});
            dv0_reg  <= $signed({1'b0, pix.pixel_v}) - $signed({1'b0, center_y_reg});
            dvfx_reg <= 34'(dv0_reg * $signed({1'b0, fxe}));
            x1i_reg  <= $signed({{(W1-16-GUARD_BITS){1'b0}}, fxe, {GUARD_BITS{1'b0}}});
            y1i_reg  <= $signed({{(W1-17-GUARD_BITS){du0_reg[16]}}, du0_reg,
                                 {GUARD_BITS{1'b0}}});
            y2i_reg  <= 59'(dvfx_reg * GAIN_Q24);
            x1s_reg  <= x1i_reg;
            y1s_reg  <= y1i_reg;
        end
    end

    // pass 1: atan(du / fx) and the scaled magnitude
    logic               p1_valid;
    logic signed [W1-1:0] p1_x;
    logic signed [ZW-1:0] p1_z;
    logic [58:0]        p1_side;

    pvac_pass #(
        .W      (W1),
        .SIDE_W (59),
        .STAGES (CORDIC_STAGES)
    ) u_pass1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .valid_in  (s2_valid_reg),
        .x_in      (x1s_reg),
        .y_in      (y1s_reg),
        .side_in   (y2i_reg),
        .valid_out (p1_valid),
        .x_out     (p1_x),
        .z_out     (p1_z),
        .side_out  (p1_side)
    );

    // stages 3 and 4: fy * magnitude split in two partial products
    logic               s3_valid_reg, s4_valid_reg;
    logic [36:0]        plo_reg, phi_reg;
    logic [58:0]        y2c_reg;
    logic signed [15:0] az3_reg, az4_reg;
    logic signed [W2-1:0] x2i_reg, y2s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            s3_valid_reg <= p1_valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            plo_reg <= fye * p1_x[20:0];
            phi_reg <= fye * p1_x[41:21];
            y2c_reg <= p1_side;
            az3_reg <= pvac_to_angle(p1_z);
            x2i_reg <= $signed({4'd0, phi_reg, 21'd0}) + $signed({25'd0, plo_reg});
            y2s_reg <= $signed({{(W2-59){y2c_reg[58]}}, y2c_reg});
            az4_reg <= az3_reg;
        end
    end

    // pass 2: elevation angle, azimuth travels alongside
    logic               p2_valid;
    logic signed [W2-1:0] p2_x;
    logic signed [ZW-1:0] p2_z;
    logic [15:0]        p2_az;

    pvac_pass #(
        .W      (W2),
        .SIDE_W (16),
        .STAGES (CORDIC_STAGES)
    ) u_pass2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .valid_in  (s4_valid_reg),
        .x_in      (x2i_reg),
        .y_in      (y2s_reg),
        .side_in   (az4_reg),
        .valid_out (p2_valid),
        .x_out     (p2_x),
        .z_out     (p2_z),
        .side_out  (p2_az)
    );

    // output register
    logic      ang_valid_reg;
    pvac_out_t ang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            ang_valid_reg <= p2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ang_reg.azimuth   <= $signed(p2_az);
            ang_reg.elevation <= pvac_to_angle(p2_z);
        end
    end

    assign ang_valid = ang_valid_reg;
    assign ang       = ang_reg;

    `PVAC_ASSERT(a_az_range, !ang_valid || (ang.azimuth <= 16'sd23040 &&
        ang.azimuth >= -16'sd23040), "azimuth out of range")
    `PVAC_ASSERT(a_el_range, !ang_valid || (ang.elevation <= 16'sd23040 &&
        ang.elevation >= -16'sd23040), "elevation out of range")
    `PVAC_ASSERT(a_p2_x_pos, !p2_valid || !p2_x[W2-1], "pass 2 magnitude went negative")
    `PVAC_ASSERT_NEXT(a_out_load, ce && p2_valid, ang_valid, "result lost at output")

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// pixel to view angle core: directed table then random requests, results
// checked in order against a cordic predictor, camera registers varied
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import pvac_pkg::*;

    localparam int STAGES = 16;
    localparam int LATENCY = 2 * STAGES + 6;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [15:0] u;
        logic [15:0] v;
        logic        known;
        logic [15:0] az;
        logic [15:0] el;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        pix_valid;
    logic        pix_stall;
    pvac_in_t    pix;
    logic        ang_valid;
    logic        ang_stall;
    pvac_out_t   ang;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [15:0] cam_fx;
    logic [15:0] cam_fy;
    logic [15:0] cam_cx;
    logic [15:0] cam_cy;

    pvac_out_t   angle_queue[$];
    int          fail_count;
    int          cycle_count;
    int          hold_cycles;
    bit          rx_busy_hold;

    pixel_to_view_angle_core #(.CORDIC_STAGES(STAGES)) uut (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
        .ang_valid(ang_valid), .ang_stall(ang_stall), .ang(ang),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // floor shift on 64 bit signed
    function automatic longint floor_shift(input longint val, input int sh);
        return val >>> sh;
    endfunction

    function automatic longint cordic_vector(inout longint xv, input longint yv);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        for (int i = 0; i < STAGES && i < TABLE_LEN; i++)
        begin
            xs = floor_shift(xv, i);
            ys = floor_shift(yv, i);
            if (yv >= 0)
            begin
                xv += ys;
                yv -= xs;
                z += longint'(ATAN_TABLE[i]);
            end
            else
            begin
                xv -= ys;
                yv += xs;
                z -= longint'(ATAN_TABLE[i]);
            end
        end
        return z;
    endfunction

    function automatic logic [15:0] angle_round(input longint z);
        longint r;
        r = floor_shift(128 - z, 8);
        if (r > 23040)
        begin
            r = 23040;
        end
        if (r < -23040)
        begin
            r = -23040;
        end
        return r[15:0];
    endfunction

    function automatic pvac_out_t view_angle(input logic [15:0] u, input logic [15:0] v);
        longint fx;
        longint fy;
        longint x1;
        longint x2;
        longint z1;
        longint z2;
        pvac_out_t res;
        fx = (cam_fx == 0) ? 1 : longint'(cam_fx);
        fy = (cam_fy == 0) ? 1 : longint'(cam_fy);
        x1 = fx <<< GUARD_BITS;
        z1 = cordic_vector(x1, (longint'(u) - longint'(cam_cx)) <<< GUARD_BITS);
        x2 = fy * x1;
        z2 = cordic_vector(x2, (longint'(v) - longint'(cam_cy)) * fx * 64'sd27628053);
        res.azimuth = angle_round(z1);
        res.elevation = angle_round(z2);
        return res;
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FOCAL_X: cam_fx = val;
            REG_FOCAL_Y: cam_fy = val;
            REG_CENTER_X: cam_cx = val;
            default: cam_cy = val;
        endcase
    endtask

    task automatic set_camera(input logic [15:0] fx, input logic [15:0] fy,
                              input logic [15:0] cx, input logic [15:0] cy);
        reg_write(REG_FOCAL_X, fx);
        reg_write(REG_FOCAL_Y, fy);
        reg_write(REG_CENTER_X, cx);
        reg_write(REG_CENTER_Y, cy);
    endtask

    task automatic drain_pipe();
        pix_valid <= 1'b0;
        while (angle_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // valid stays high after the accept so requests can follow back to back
    task automatic send_request(input logic [15:0] u, input logic [15:0] v, input int gap);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix.pixel_u <= u;
        pix.pixel_v <= v;
        @(posedge clk);
        while (pix_stall)
        begin
            @(posedge clk);
        end
        angle_queue.push_back(view_angle(u, v));
    endtask

    task automatic send_random(input int count, input int max_gap);
        logic [15:0] u;
        logic [15:0] v;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                u = 16'($urandom);
                v = 16'($urandom);
            end
            else
            begin
                u = cam_cx + 16'($signed($urandom_range(0, 8191)) - 4096);
                v = cam_cy + 16'($signed($urandom_range(0, 8191)) - 4096);
            end
            send_request(u, v, (max_gap == 0) ? 0 : $urandom_range(0, max_gap));
        end
    endtask

    // receiver: random stall, optional long hold
    initial
    begin
        int stall_len;
        ang_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_busy_hold)
            begin
                ang_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                rx_busy_hold = 1'b0;
                ang_stall <= 1'b0;
            end
            else
            begin
                stall_len = $urandom_range(0, 11);
                if (stall_len != 0)
                begin
                    ang_stall <= 1'b1;
                    repeat (stall_len) @(posedge clk);
                    ang_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        pvac_out_t want;
        if (rst_n && ang_valid && !ang_stall)
        begin
            if (angle_queue.size() == 0)
            begin
                $error("unexpected result az=%0d el=%0d", ang.azimuth, ang.elevation);
                fail_count++;
            end
            else
            begin
                want = angle_queue.pop_front();
                if (ang.azimuth !== want.azimuth)
                begin
                    $error("azimuth expected %0d actual %0d", want.azimuth, ang.azimuth);
                    fail_count++;
                end
                if (ang.elevation !== want.elevation)
                begin
                    $error("elevation expected %0d actual %0d",
                           want.elevation, ang.elevation);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t rows[$];
        pvac_out_t got;
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        rx_busy_hold = 1'b0;
        hold_cycles = 0;
        cam_fx = 16'd8192;
        cam_fy = 16'd8192;
        cam_cx = 16'd5120;
        cam_cy = 16'd3840;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // centre of the reset camera looks straight ahead
        rows.push_back('{16'd5120, 16'd3840, 1'b1, 16'd0, 16'd0});
        rows.push_back('{16'd0, 16'd0, 1'b0, 16'd0, 16'd0});
        rows.push_back('{16'hffff, 16'hffff, 1'b0, 16'd0, 16'd0});
        rows.push_back('{16'hffff, 16'd0, 1'b0, 16'd0, 16'd0});
        rows.push_back('{16'd0, 16'hffff, 1'b0, 16'd0, 16'd0});
        rows.push_back('{16'd13312, 16'd3840, 1'b0, 16'd0, 16'd0});
        rows.push_back('{16'd5120, 16'd12032, 1'b0, 16'd0, 16'd0});
        rows.push_back('{16'haaaa, 16'h5555, 1'b0, 16'd0, 16'd0});
        rows.push_back('{16'h5555, 16'haaaa, 1'b0, 16'd0, 16'd0});
        foreach (rows[i])
        begin
            send_request(rows[i].u, rows[i].v, 0);
            if (rows[i].known)
            begin
                got = angle_queue[$];
                if (got.azimuth !== rows[i].az || got.elevation !== rows[i].el)
                begin
                    $error("table row %0d expected %0d/%0d", i, rows[i].az, rows[i].el);
                    fail_count++;
                end
            end
        end
        drain_pipe();

        // zero focal lengths act as one, far views saturate
        set_camera(16'd0, 16'd0, 16'd0, 16'd0);
        send_request(16'hffff, 16'hffff, 0);
        send_request(16'd0, 16'd0, 0);
        send_request(16'd1, 16'd0, 0);
        drain_pipe();
        set_camera(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_request(16'd0, 16'd0, 0);
        send_request(16'hffff, 16'hffff, 0);
        send_request(16'h8000, 16'h7fff, 0);
        drain_pipe();

        set_camera(16'd8192, 16'd8192, 16'd5120, 16'd3840);
        send_random(300, 11);
        drain_pipe();

        // long receiver hold while requests keep coming
        hold_cycles = 200;
        rx_busy_hold = 1'b1;
        send_random(100, 0);
        drain_pipe();

        set_camera(16'd1, 16'd65535, 16'd32768, 16'd100);
        send_random(150, 11);
        drain_pipe();
        set_camera(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)),
                   16'($urandom), 16'($urandom));
        send_random(200, 11);
        drain_pipe();
        set_camera(16'd65535, 16'd1, 16'd0, 16'd65535);
        send_random(150, 5);
        drain_pipe();
        set_camera(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        send_random(100, 11);
        drain_pipe();

        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/pvac_pkg.sv
design/pvac_cell.sv
design/pvac_pass.sv
design/pixel_to_view_angle_core.sv
verif/tb_top.sv
